// ----- rtl/rle_one_bit_sample_player_defines.svh -----
// Assertion helpers for the sample player
`ifndef RLE_ONE_BIT_SAMPLE_PLAYER_DEFINES_SVH
`define RLE_ONE_BIT_SAMPLE_PLAYER_DEFINES_SVH

// Checked on every clock edge outside reset
`define RLESP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("rlesp assertion failed");

// Checked on every clock edge, reset included
`define RLESP_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) else $error("rlesp assertion failed");

`endif

// ----- rtl/rlesp_pkg.sv -----
`timescale 1ns / 1ps

package rlesp_pkg;

  // Default storage shape
  localparam int TABLE_DEPTH_DEF = 1024;
  localparam int RUN_WIDTH_DEF   = 16;

  // Fixed field widths
  localparam int CMD_W      = 2;
  localparam int IDX_W      = 10;
  localparam int RUNLEN_W   = 16;
  localparam int POS_W      = 10;
  localparam int LEN_W      = 11;
  localparam int STR_W      = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Command codes; code 3 is ignored
  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE  = 2'd0,
    CMD_REWIND = 2'd1,
    CMD_TICK   = 2'd2
  } cmd_e;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENABLE    = 2'd0,
    REG_TABLE_LEN = 2'd1,
    REG_STRETCH   = 2'd2
  } reg_e;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_REWIND,
    ST_SKIP
  } state_e;

endpackage

// ----- rtl/rlesp_cmd_if.sv -----
`timescale 1ns / 1ps

// Command channel
interface rlesp_cmd_if;
  logic                           valid;
  logic                           ready;
  logic [rlesp_pkg::CMD_W-1:0]    command;
  logic [rlesp_pkg::IDX_W-1:0]    entry_index;
  logic [rlesp_pkg::RUNLEN_W-1:0] run_length;
  logic                           buffer_start;

  modport source (
    output valid, command, entry_index, run_length, buffer_start,
    input  ready
  );
  modport sink (
    input  valid, command, entry_index, run_length, buffer_start,
    output ready
  );
endinterface

// ----- rtl/rlesp_res_if.sv -----
`timescale 1ns / 1ps

// Result channel
interface rlesp_res_if;
  logic                        valid;
  logic                        ready;
  logic                        sample_bit;
  logic [rlesp_pkg::POS_W-1:0] position;

  modport source (
    output valid, sample_bit, position,
    input  ready
  );
  modport sink (
    input  valid, sample_bit, position,
    output ready
  );
endinterface

// ----- rtl/rle_one_bit_sample_player.sv -----
`timescale 1ns / 1ps
// Channel   Dir  Payload                                           Notes
// cmd_i     in   command, entry_index, run_length, buffer_start    write / rewind / tick
// res_o     out  sample_bit, position                              one per playing tick
// cfg       in   cfg_we_i, cfg_idx_i, cfg_wdata_i                  enable, length, stretch
//
// Write and non-ending tick complete in idle. A tick that ends a run goes through the
// skip state, where each visited entry costs one read of the run table
// (registered read data). Rewind goes through the rewind state, one read per entry visited.
// Reset clears control and config registers; the run table is not cleared.
// A result waits in the output register; new transactions are taken only in idle
// and only when that register is empty or draining in the same cycle.

`include "rle_one_bit_sample_player_defines.svh"

module rle_one_bit_sample_player #(
  parameter int TABLE_DEPTH = rlesp_pkg::TABLE_DEPTH_DEF,
  parameter int RUN_WIDTH   = rlesp_pkg::RUN_WIDTH_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [rlesp_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [rlesp_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  rlesp_cmd_if.sink                          cmd_i,
  rlesp_res_if.source                        res_o
);

  localparam int PW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int LW = (PW + 1 > rlesp_pkg::LEN_W) ? PW + 1 : rlesp_pkg::LEN_W;
  localparam int WW = (RUN_WIDTH > rlesp_pkg::RUNLEN_W) ? RUN_WIDTH : rlesp_pkg::RUNLEN_W;
  localparam int SW = rlesp_pkg::STR_W;

  // Configuration registers
  logic                          enable_q;
  logic [rlesp_pkg::LEN_W-1:0]   tlen_q;
  logic [SW-1:0]                 stretch_q;

  // Control and playback state
  rlesp_pkg::state_e state_q, state_d;
  logic [PW-1:0]        pos_q, pos_d;
  logic [RUN_WIDTH-1:0] run_left_q, run_left_d;
  logic                 level_q, level_d;
  logic [SW-1:0]        scnt_q, scnt_d;
  logic [LW-1:0]        moves_q, moves_d;
  logic                 emit_q, emit_d;

  // Output register
  logic                        out_vld_q, out_vld_d;
  logic                        out_bit_q, out_bit_d;
  logic [rlesp_pkg::POS_W-1:0] out_pos_q, out_pos_d;
  logic                        out_load;

  // Run table memory
  logic [RUN_WIDTH-1:0] mem [TABLE_DEPTH];
  logic [RUN_WIDTH-1:0] rdata_q;
  logic [PW-1:0]        rd_addr;
  logic                 wr_en;
  logic [PW-1:0]        wr_addr;
  logic [RUN_WIDTH-1:0] wr_data;

  // Helpers
  logic [LW-1:0]        eff_len, tlen_ext, idx_ext, nxt_ext, pos_ext, pos_inc;
  logic [WW-1:0]        rl_ext;
  logic [PW-1:0]        adv_pos;
  logic [SW-1:0]        st_eff, cnt_inc, cnt_nxt;
  logic                 take, play, len_nz, slot_free, idle_rdy, acc;
  logic                 rew_more, skip_more, idx_ok;
  rlesp_pkg::cmd_e      cmd;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q  <= 1'b0;
      tlen_q    <= '0;
      stretch_q <= SW'(1);
    end else if (cfg_we_i) begin
      unique case (rlesp_pkg::reg_e'(cfg_idx_i))
        rlesp_pkg::REG_ENABLE:    enable_q  <= cfg_wdata_i[0];
        rlesp_pkg::REG_TABLE_LEN: tlen_q    <= cfg_wdata_i[rlesp_pkg::LEN_W-1:0];
        rlesp_pkg::REG_STRETCH:   stretch_q <= cfg_wdata_i[SW-1:0];
        default: ;
      endcase
    end
  end

  // Effective length, position arithmetic, stretch counting
  always_comb begin
    tlen_ext = LW'(tlen_q);
    eff_len  = (tlen_ext > LW'(TABLE_DEPTH)) ? LW'(TABLE_DEPTH) : tlen_ext;
    len_nz   = (eff_len != '0);
    play     = enable_q && len_nz;

    pos_ext  = LW'(pos_q);
    pos_inc  = pos_ext + LW'(1);
    nxt_ext  = pos_inc;
    adv_pos  = (nxt_ext >= eff_len) ? '0 : nxt_ext[PW-1:0];

    rew_more  = (rdata_q == '0) && (pos_inc < eff_len);
    skip_more = (rdata_q == '0) && (moves_q < eff_len);

    idx_ext = LW'(cmd_i.entry_index);
    idx_ok  = idx_ext < LW'(TABLE_DEPTH);
    wr_addr = idx_ext[PW-1:0];
    rl_ext  = WW'(cmd_i.run_length);
    wr_data = rl_ext[RUN_WIDTH-1:0];

    st_eff  = (stretch_q == '0) ? SW'(1) : stretch_q;
    cnt_inc = scnt_q + SW'(1);
    if (cmd_i.buffer_start) begin
      cnt_nxt = '0;
      take    = (st_eff == SW'(1));
    end else if (cnt_inc >= st_eff) begin
      cnt_nxt = '0;
      take    = 1'b1;
    end else begin
      cnt_nxt = cnt_inc;
      take    = 1'b0;
    end
  end

  // Handshake
  assign cmd       = rlesp_pkg::cmd_e'(cmd_i.command);
  assign slot_free = !out_vld_q || res_o.ready;
  assign idle_rdy  = (state_q == rlesp_pkg::ST_IDLE) && slot_free;
  assign acc       = cmd_i.valid && idle_rdy;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rlesp_pkg::ST_IDLE: begin
        if (acc && cmd == rlesp_pkg::CMD_REWIND && len_nz) begin
          state_d = rlesp_pkg::ST_REWIND;
        end else if (acc && cmd == rlesp_pkg::CMD_TICK && play && take &&
                     run_left_q <= RUN_WIDTH'(1)) begin
          state_d = rlesp_pkg::ST_SKIP;
        end
      end
      rlesp_pkg::ST_REWIND: if (!rew_more) state_d = rlesp_pkg::ST_IDLE;
      rlesp_pkg::ST_SKIP:   if (!skip_more) state_d = rlesp_pkg::ST_IDLE;
      default:              state_d = rlesp_pkg::ST_IDLE;
    endcase
  end

  // Datapath and memory control
  always_comb begin
    pos_d      = pos_q;
    run_left_d = run_left_q;
    level_d    = level_q;
    scnt_d     = scnt_q;
    moves_d    = moves_q;
    emit_d     = emit_q;
    out_load   = 1'b0;
    out_bit_d  = out_bit_q;
    out_pos_d  = out_pos_q;
    wr_en      = 1'b0;
    rd_addr    = pos_q;
    unique case (state_q)
      rlesp_pkg::ST_IDLE: begin
        if (acc) begin
          unique case (cmd)
            rlesp_pkg::CMD_WRITE: wr_en = idx_ok;
            rlesp_pkg::CMD_REWIND: begin
              if (len_nz) begin
                pos_d   = '0;
                rd_addr = '0;
              end
            end
            rlesp_pkg::CMD_TICK: begin
              if (play) begin
                emit_d = level_q;
                scnt_d = cnt_nxt;
                if (take && run_left_q <= RUN_WIDTH'(1)) begin
                  // run ends: step to next entry, fetch it
                  pos_d   = adv_pos;
                  rd_addr = adv_pos;
                  level_d = ~level_q;
                  moves_d = LW'(1);
                end else begin
                  if (take) run_left_d = run_left_q - RUN_WIDTH'(1);
                  out_load  = 1'b1;
                  out_bit_d = level_q;
                  out_pos_d = pos_ext[rlesp_pkg::POS_W-1:0];
                end
              end
            end
            default: ;
          endcase
        end
      end
      rlesp_pkg::ST_REWIND: begin
        // skip zero entries, never past the last one
        if (rew_more) begin
          pos_d   = pos_inc[PW-1:0];
          rd_addr = pos_inc[PW-1:0];
          level_d = ~level_q;
        end else begin
          run_left_d = rdata_q;
        end
      end
      rlesp_pkg::ST_SKIP: begin
        // skip zero entries with wrap, bounded by the table length
        if (skip_more) begin
          pos_d   = adv_pos;
          rd_addr = adv_pos;
          level_d = ~level_q;
          moves_d = moves_q + LW'(1);
        end else begin
          run_left_d = rdata_q;
          out_load   = 1'b1;
          out_bit_d  = emit_q;
          out_pos_d  = pos_ext[rlesp_pkg::POS_W-1:0];
        end
      end
      default: ;
    endcase
  end

  // Output slot
  always_comb begin
    if (out_load) begin
      out_vld_d = 1'b1;
    end else if (res_o.ready) begin
      out_vld_d = 1'b0;
    end else begin
      out_vld_d = out_vld_q;
    end
  end

  // Outputs
  assign cmd_i.ready      = idle_rdy;
  assign res_o.valid      = out_vld_q;
  assign res_o.sample_bit = out_bit_q;
  assign res_o.position   = out_pos_q;

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= rlesp_pkg::ST_IDLE;
      pos_q      <= '0;
      run_left_q <= '0;
      level_q    <= 1'b0;
      scnt_q     <= '0;
      moves_q    <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      pos_q      <= pos_d;
      run_left_q <= run_left_d;
      level_q    <= level_d;
      scnt_q     <= scnt_d;
      moves_q    <= moves_d;
      out_vld_q  <= out_vld_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    emit_q    <= emit_d;
    out_bit_q <= out_bit_d;
    out_pos_q <= out_pos_d;
  end

  // Run table: one write and one read per cycle, registered read data
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata_q <= mem[rd_addr];
  end

  // Checks
  `RLESP_ASSERT(a_no_overwrite, out_load |-> slot_free)
  `RLESP_ASSERT(a_rewind_silent, state_q == rlesp_pkg::ST_REWIND |-> !out_load)
  `RLESP_ASSERT(a_skip_counted, state_q == rlesp_pkg::ST_SKIP |-> moves_q != '0)
  `RLESP_ASSERT_ALWAYS(a_busy_not_ready, state_q != rlesp_pkg::ST_IDLE |-> !cmd_i.ready)

endmodule
